// ----- hdl/htc_pkg.sv -----
// Shared types, register indexes, fault codes and conversion constants for the
// hot-swap telemetry converter. No dependencies.
package htc_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_FLOOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_FLOOR   = 1'd1;

  localparam logic signed [15:0] CURRENT_FLOOR_RST = 16'sd12;
  localparam logic signed [15:0] POWER_FLOOR_RST   = 16'sd5;

  // Priority fault codes.
  localparam logic [2:0] FAULT_NONE        = 3'd0;
  localparam logic [2:0] FAULT_COMMS       = 3'd1;
  localparam logic [2:0] FAULT_MOSFET      = 3'd2;
  localparam logic [2:0] FAULT_BREAKER     = 3'd3;
  localparam logic [2:0] FAULT_OVERVOLT    = 3'd4;
  localparam logic [2:0] FAULT_OVERTEMP    = 3'd5;
  localparam logic [2:0] FAULT_OVERCURRENT = 3'd6;

  // Current: (2512*i + 26700) / 1000. The magnitude is clamped just past the
  // saturation point so that the reciprocal multiply stays exact.
  localparam int CUR_GAIN  = 2512;
  localparam int CUR_OFS   = 26700;
  localparam int CUR_DIV   = 1000;
  localparam int CUR_NUM_W = 28;
  localparam int CUR_MAG_W = 25;
  localparam int CUR_S     = 35;
  localparam int CUR_M_W   = 26;
  localparam int CUR_LIM   = 32768 * CUR_DIV;
  localparam logic [CUR_M_W-1:0] CUR_M =
    CUR_M_W'(((64'd1 << CUR_S) + 64'(CUR_DIV) - 64'd1) / 64'(CUR_DIV));

  // Voltages: (10000*v + offset) / divisor, signed.
  localparam int VLT_GAIN  = 10000;
  localparam int VOUT_OFS  = 240000;
  localparam int VIN_OFS   = 120000;
  localparam int VOUT_DIV  = 4587;
  localparam int VIN_DIV   = 4578;
  localparam int VLT_NUM_W = 30;
  localparam int VLT_MAG_W = 28;
  localparam int VLT_S     = 41;
  localparam int VLT_M_W   = 29;
  localparam int VOUT_LIM  = 32769 * VOUT_DIV;
  localparam int VIN_LIM   = 32769 * VIN_DIV;
  localparam logic [VLT_M_W-1:0] VOUT_M =
    VLT_M_W'(((64'd1 << VLT_S) + 64'(VOUT_DIV) - 64'd1) / 64'(VOUT_DIV));
  localparam logic [VLT_M_W-1:0] VIN_M =
    VLT_M_W'(((64'd1 << VLT_S) + 64'(VIN_DIV) - 64'd1) / 64'(VIN_DIV));

  // Power: (95*p + 240) / 4.
  localparam int PWR_GAIN  = 95;
  localparam int PWR_OFS   = 240;
  localparam int PWR_NUM_W = 23;
  localparam int PWR_Q_W   = 20;

  // Energy increment: 25*power/9, folded into one constant multiply.
  localparam int EN_DIV = 9;
  localparam int EN_S   = 24;
  localparam int EN_K_W = 26;
  localparam int EN_INC_W = 17;
  localparam logic [EN_K_W-1:0] EN_K =
    EN_K_W'(64'd25 * (((64'd1 << EN_S) + 64'(EN_DIV) - 64'd1) / 64'(EN_DIV)));
  localparam int ENERGY_MAX_STEP = (32767 * 25) / EN_DIV;

  typedef struct packed {
    logic [7:0]         fault_byte;
    logic [7:0]         warn_byte;
    logic signed [15:0] current_raw;
    logic signed [15:0] vo_raw;
    logic signed [15:0] vin_raw;
    logic signed [15:0] power_raw;
    logic signed [15:0] temp_raw;
  } raw_rec_t;

  typedef struct packed {
    logic [2:0]           fault_code;
    logic                 pwr_ok;
    logic                 dev_off;
    logic                 cur_zero;
    logic [CUR_MAG_W-1:0] cur_mag;
    logic                 vout_neg;
    logic [VLT_MAG_W-1:0] vout_mag;
    logic                 vin_neg;
    logic [VLT_MAG_W-1:0] vin_mag;
    logic                 pwr_zero;
    logic [PWR_Q_W-1:0]   pwr_q;
    logic signed [11:0]   temp;
  } num_rec_t;

  typedef struct packed {
    logic [2:0]         fault_code;
    logic               pwr_ok;
    logic               dev_off;
    logic [14:0]        current_10ma;
    logic signed [15:0] vo_10mv;
    logic signed [15:0] vi_10mv;
    logic [14:0]        power_100mw;
    logic signed [11:0] temp_degc;
  } scl_rec_t;

  typedef struct packed {
    logic load_num;
    logic load_scl;
  } stage_ctl_t;

endpackage

// ----- hdl/hotswap_telemetry_converter.sv -----
// Top level of the hot-swap telemetry converter: input register, scaling
// datapath, energy accumulator and result register. Depends on htc_pkg and
// htc_convert.
//
// One telemetry record is taken per clock cycle while the result side keeps
// up; it then passes through four register stages that bracket the constant
// multiplies: input capture, numerators, reciprocal-multiply scaling, and the
// result register with the energy accumulator. Each stage holds when the one
// after it is full and stalled, and an empty stage always takes new data, so
// throughput stays at one transaction per cycle while the result side keeps
// up. The energy total starts at zero after reset and advances once per
// delivered result; there is no clearing pass. The user must write the floors
// through the configuration port only while no transaction is in flight; the
// block itself does not enforce this.
module hotswap_telemetry_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [htc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_fault_byte,
  input  logic [7:0]                     in_warn_byte,
  input  logic signed [15:0]             in_current_raw,
  input  logic signed [15:0]             in_vo_raw,
  input  logic signed [15:0]             in_vin_raw,
  input  logic signed [15:0]             in_power_raw,
  input  logic signed [15:0]             in_temp_raw,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_fault_code,
  output logic                           out_pwr_ok,
  output logic                           out_dev_off,
  output logic [14:0]                    out_current_10ma,
  output logic signed [15:0]             out_vo_10mv,
  output logic signed [15:0]             out_vi_10mv,
  output logic [14:0]                    out_power_100mw,
  output logic signed [11:0]             out_temp_degc,
  output logic signed [31:0]             out_energy_uwh
);
  import htc_pkg::*;

  logic signed [15:0] cur_floor_r, pwr_floor_r;
  logic               v1_r, v2_r, v3_r, out_valid_r;
  logic               rdy2, rdy3, rdy4, ld4;
  raw_rec_t           raw_r;
  scl_rec_t           scl;
  scl_rec_t           res_r;
  stage_ctl_t         ctl;
  logic signed [31:0] energy_r, energy_nxt;
  logic [15+EN_K_W-1:0] en_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_floor_r <= CURRENT_FLOOR_RST;
      pwr_floor_r <= POWER_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURRENT_FLOOR: cur_floor_r <= $signed(cfg_wdata);
        REG_POWER_FLOOR:   pwr_floor_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or when its contents move on this cycle.
  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;
  assign ld4      = rdy4 && v3_r;

  assign ctl.load_num = rdy2 && v1_r;
  assign ctl.load_scl = rdy3 && v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r.fault_byte  <= in_fault_byte;
      raw_r.warn_byte   <= in_warn_byte;
      raw_r.current_raw <= in_current_raw;
      raw_r.vo_raw      <= in_vo_raw;
      raw_r.vin_raw     <= in_vin_raw;
      raw_r.power_raw   <= in_power_raw;
      raw_r.temp_raw    <= in_temp_raw;
    end
  end

  htc_convert u_convert (
    .clk       (clk),
    .ctl       (ctl),
    .raw       (raw_r),
    .cur_floor (cur_floor_r),
    .pwr_floor (pwr_floor_r),
    .scl       (scl)
  );

  // 25*power/9 as one multiply by a scaled reciprocal, then wrap into the total.
  always_comb begin
    en_prod    = (15+EN_K_W)'(scl.power_100mw) * (15+EN_K_W)'(EN_K);
    energy_nxt = energy_r + $signed(32'(en_prod[EN_S+EN_INC_W-1:EN_S]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= 32'sd0;
    end else if (ld4) begin
      energy_r <= energy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      res_r <= scl;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fault_code   = res_r.fault_code;
  assign out_pwr_ok       = res_r.pwr_ok;
  assign out_dev_off      = res_r.dev_off;
  assign out_current_10ma = res_r.current_10ma;
  assign out_vo_10mv      = res_r.vo_10mv;
  assign out_vi_10mv      = res_r.vi_10mv;
  assign out_power_100mw  = res_r.power_100mw;
  assign out_temp_degc    = res_r.temp_degc;
  assign out_energy_uwh   = energy_r;

`ifndef NO_ASSERTIONS
  a_energy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ld4 |=> $stable(energy_r))
    else $error("energy total changed without a new result");

  a_energy_step: assert property (@(posedge clk) disable iff (!rst_n)
    ld4 |=> ($unsigned(energy_r - $past(energy_r)) <= 32'(ENERGY_MAX_STEP)))
    else $error("energy increment exceeds the largest possible step");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.fault_code <= FAULT_OVERCURRENT))
    else $error("fault code out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> v3_r)
    else $error("scaled transaction dropped while the result register was stalled");
`endif

endmodule

// ----- hdl/htc_convert.sv -----
// Two-stage scaling datapath: numerators and clamped magnitudes, then
// reciprocal multiplies and saturation. Depends on htc_pkg.
module htc_convert (
  input  logic                  clk,
  input  htc_pkg::stage_ctl_t   ctl,
  input  htc_pkg::raw_rec_t     raw,
  input  logic signed [15:0]    cur_floor,
  input  logic signed [15:0]    pwr_floor,
  output htc_pkg::scl_rec_t     scl
);
  import htc_pkg::*;

  num_rec_t num_r, num_nxt;
  scl_rec_t scl_r, scl_nxt;

  logic signed [CUR_NUM_W-1:0] cur_num;
  logic signed [VLT_NUM_W-1:0] vout_num, vout_abs;
  logic signed [VLT_NUM_W-1:0] vin_num, vin_abs;
  logic signed [PWR_NUM_W-1:0] pwr_num;
  logic signed [15:0]          temp_adj;

  always_comb begin
    cur_num  = CUR_NUM_W'($signed(raw.current_raw)) * CUR_NUM_W'(CUR_GAIN)
             + CUR_NUM_W'(CUR_OFS);
    vout_num = VLT_NUM_W'($signed(raw.vo_raw)) * VLT_NUM_W'(VLT_GAIN)
             + VLT_NUM_W'(VOUT_OFS);
    vin_num  = VLT_NUM_W'($signed(raw.vin_raw)) * VLT_NUM_W'(VLT_GAIN)
             + VLT_NUM_W'(VIN_OFS);
    pwr_num  = PWR_NUM_W'($signed(raw.power_raw)) * PWR_NUM_W'(PWR_GAIN)
             + PWR_NUM_W'(PWR_OFS);
    vout_abs = vout_num[VLT_NUM_W-1] ? -vout_num : vout_num;
    vin_abs  = vin_num[VLT_NUM_W-1] ? -vin_num : vin_num;
    // Bias negative temperatures so the arithmetic shift truncates toward zero.
    temp_adj = raw.temp_raw + (raw.temp_raw[15] ? 16'sd15 : 16'sd0);

    num_nxt.pwr_ok  = raw.warn_byte[3];
    num_nxt.dev_off = raw.fault_byte[6];
    priority if (raw.fault_byte[1]) num_nxt.fault_code = FAULT_COMMS;
    else if (raw.warn_byte[0])      num_nxt.fault_code = FAULT_MOSFET;
    else if (raw.fault_byte[0])     num_nxt.fault_code = FAULT_BREAKER;
    else if (raw.fault_byte[4])     num_nxt.fault_code = FAULT_OVERVOLT;
    else if (raw.fault_byte[2])     num_nxt.fault_code = FAULT_OVERTEMP;
    else if (raw.fault_byte[3])     num_nxt.fault_code = FAULT_OVERCURRENT;
    else                            num_nxt.fault_code = FAULT_NONE;

    // A negative numerator truncates to a value that clamps to zero anyway.
    num_nxt.cur_zero = (raw.current_raw < cur_floor) || cur_num[CUR_NUM_W-1];
    num_nxt.cur_mag  = (cur_num > CUR_NUM_W'(CUR_LIM)) ? CUR_MAG_W'(CUR_LIM)
                     : cur_num[CUR_MAG_W-1:0];
    num_nxt.vout_neg = vout_num[VLT_NUM_W-1];
    num_nxt.vout_mag = (vout_abs > VLT_NUM_W'(VOUT_LIM)) ? VLT_MAG_W'(VOUT_LIM)
                     : vout_abs[VLT_MAG_W-1:0];
    num_nxt.vin_neg  = vin_num[VLT_NUM_W-1];
    num_nxt.vin_mag  = (vin_abs > VLT_NUM_W'(VIN_LIM)) ? VLT_MAG_W'(VIN_LIM)
                     : vin_abs[VLT_MAG_W-1:0];
    num_nxt.pwr_zero = (raw.power_raw < pwr_floor) || pwr_num[PWR_NUM_W-1];
    num_nxt.pwr_q    = pwr_num[PWR_Q_W+1:2];
    num_nxt.temp     = 12'(temp_adj >>> 4);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_num) begin
      num_r <= num_nxt;
    end
  end

  logic [CUR_MAG_W+CUR_M_W-1:0] cur_prod;
  logic [VLT_MAG_W+VLT_M_W-1:0] vout_prod, vin_prod;
  logic [15:0]                  cur_q, vout_q, vin_q;

  always_comb begin
    cur_prod  = (CUR_MAG_W+CUR_M_W)'(num_r.cur_mag) * (CUR_MAG_W+CUR_M_W)'(CUR_M);
    vout_prod = (VLT_MAG_W+VLT_M_W)'(num_r.vout_mag) * (VLT_MAG_W+VLT_M_W)'(VOUT_M);
    vin_prod  = (VLT_MAG_W+VLT_M_W)'(num_r.vin_mag) * (VLT_MAG_W+VLT_M_W)'(VIN_M);
    cur_q  = cur_prod[CUR_S+15:CUR_S];
    vout_q = vout_prod[VLT_S+15:VLT_S];
    vin_q  = vin_prod[VLT_S+15:VLT_S];

    scl_nxt.fault_code = num_r.fault_code;
    scl_nxt.pwr_ok     = num_r.pwr_ok;
    scl_nxt.dev_off    = num_r.dev_off;
    scl_nxt.temp_degc  = num_r.temp;

    if (num_r.cur_zero) begin
      scl_nxt.current_10ma = 15'd0;
    end else if (cur_q[15]) begin
      scl_nxt.current_10ma = 15'h7fff;
    end else begin
      scl_nxt.current_10ma = cur_q[14:0];
    end

    if (num_r.pwr_zero) begin
      scl_nxt.power_100mw = 15'd0;
    end else if (num_r.pwr_q > PWR_Q_W'(32767)) begin
      scl_nxt.power_100mw = 15'h7fff;
    end else begin
      scl_nxt.power_100mw = num_r.pwr_q[14:0];
    end

    // Negative side saturates one count further out than the positive side.
    if (num_r.vout_neg) begin
      scl_nxt.vo_10mv = (vout_q > 16'd32768) ? 16'sh8000 : $signed(~vout_q + 16'd1);
    end else begin
      scl_nxt.vo_10mv = vout_q[15] ? 16'sh7fff : $signed(vout_q);
    end
    if (num_r.vin_neg) begin
      scl_nxt.vi_10mv = (vin_q > 16'd32768) ? 16'sh8000 : $signed(~vin_q + 16'd1);
    end else begin
      scl_nxt.vi_10mv = vin_q[15] ? 16'sh7fff : $signed(vin_q);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_scl) begin
      scl_r <= scl_nxt;
    end
  end

  assign scl = scl_r;

endmodule

// ----- tb/hotswap_telemetry_converter_checker.sv -----
// Scoreboard for the hot-swap telemetry converter: watches the configuration port and both
// channels, predicts every result and compares it field by field. Depends on htc_pkg.
module hotswap_telemetry_converter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_fault_byte,
  input  logic [7:0]                    in_warn_byte,
  input  logic signed [15:0]            in_current_raw,
  input  logic signed [15:0]            in_vo_raw,
  input  logic signed [15:0]            in_vin_raw,
  input  logic signed [15:0]            in_power_raw,
  input  logic signed [15:0]            in_temp_raw,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    out_fault_code,
  input  logic                          out_pwr_ok,
  input  logic                          out_dev_off,
  input  logic [14:0]                   out_current_10ma,
  input  logic signed [15:0]            out_vo_10mv,
  input  logic signed [15:0]            out_vi_10mv,
  input  logic [14:0]                   out_power_100mw,
  input  logic signed [11:0]            out_temp_degc,
  input  logic signed [31:0]            out_energy_uwh,
  output int                            mismatch_count,
  output int                            pending_count,
  output int                            checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import htc_pkg::*;

  typedef struct packed {
    logic [2:0]         fault_code;
    logic               pwr_ok;
    logic               dev_off;
    logic [14:0]        current_10ma;
    logic signed [15:0] vo_10mv;
    logic signed [15:0] vi_10mv;
    logic [14:0]        power_100mw;
    logic signed [11:0] temp_degc;
    logic signed [31:0] energy_uwh;
  } telemetry_t;

  telemetry_t         telemetry_q[$];
  logic signed [15:0] current_floor;
  logic signed [15:0] power_floor;
  logic [31:0]        energy_acc;

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Scales one record; energy_prev is the running total before this record.
  function automatic telemetry_t scale_record(
    input logic [7:0]         fb,
    input logic [7:0]         wb,
    input logic signed [15:0] cur_raw,
    input logic signed [15:0] vo_raw,
    input logic signed [15:0] vin_raw,
    input logic signed [15:0] pwr_raw,
    input logic signed [15:0] tmp_raw,
    input logic signed [15:0] cur_floor,
    input logic signed [15:0] pwr_floor,
    input logic [31:0]        energy_prev
  );
    telemetry_t r;
    longint     ci;
    longint     vo;
    longint     vi;
    longint     pw;
    longint     tr;
    longint     cur;
    longint     pwr;
    ci = cur_raw;
    vo = vo_raw;
    vi = vin_raw;
    pw = pwr_raw;
    tr = tmp_raw;

    if (fb[1])      r.fault_code = FAULT_COMMS;
    else if (wb[0]) r.fault_code = FAULT_MOSFET;
    else if (fb[0]) r.fault_code = FAULT_BREAKER;
    else if (fb[4]) r.fault_code = FAULT_OVERVOLT;
    else if (fb[2]) r.fault_code = FAULT_OVERTEMP;
    else if (fb[3]) r.fault_code = FAULT_OVERCURRENT;
    else            r.fault_code = FAULT_NONE;
    r.pwr_ok  = wb[3];
    r.dev_off = fb[6];

    // Division on signed 64-bit operands truncates toward zero, as the block does.
    cur = (ci < longint'(cur_floor)) ? 0 : saturate((2512 * ci + 26700) / 1000, 0, 32767);
    pwr = (pw < longint'(pwr_floor)) ? 0 : saturate((95 * pw + 240) / 4, 0, 32767);
    r.current_10ma = 15'(cur);
    r.power_100mw  = 15'(pwr);
    r.vo_10mv      = 16'(saturate((10000 * vo + 240000) / 4587, -32768, 32767));
    r.vi_10mv      = 16'(saturate((10000 * vi + 120000) / 4578, -32768, 32767));
    r.temp_degc    = 12'(tr / 16);
    r.energy_uwh   = energy_prev + 32'((pwr * 25) / 9);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got)
      note_failure($sformatf("result %0d: %s expected %0d, got %0d", checked_count, name,
                             want, got));
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
  end

  always @(posedge clk) begin
    telemetry_t want;
    if (!rst_n) begin
      current_floor = CURRENT_FLOOR_RST;
      power_floor   = POWER_FLOOR_RST;
      energy_acc    = '0;
      telemetry_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CURRENT_FLOOR: current_floor = cfg_wdata;
          REG_POWER_FLOOR:   power_floor   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (telemetry_q.size() == 0) begin
          note_failure($sformatf("unexpected result transaction, energy %0d", out_energy_uwh));
        end else begin
          want = telemetry_q.pop_front();
          check_field("fault_code", want.fault_code, out_fault_code);
          check_field("pwr_ok", want.pwr_ok, out_pwr_ok);
          check_field("dev_off", want.dev_off, out_dev_off);
          check_field("current_10ma", want.current_10ma, out_current_10ma);
          check_field("vo_10mv", want.vo_10mv, out_vo_10mv);
          check_field("vi_10mv", want.vi_10mv, out_vi_10mv);
          check_field("power_100mw", want.power_100mw, out_power_100mw);
          check_field("temp_degc", want.temp_degc, out_temp_degc);
          check_field("energy_uwh", want.energy_uwh, out_energy_uwh);
        end
        checked_count++;
      end
      if (in_valid && in_ready) begin
        want = scale_record(in_fault_byte, in_warn_byte, in_current_raw, in_vo_raw,
                            in_vin_raw, in_power_raw, in_temp_raw, current_floor,
                            power_floor, energy_acc);
        energy_acc = want.energy_uwh;
        telemetry_q.push_back(want);
      end
    end
    pending_count <= telemetry_q.size();
  end

endmodule

// ----- tb/hotswap_telemetry_converter_test.sv -----
// Top of the hot-swap telemetry converter testbench: clock, reset, floor settings, record
// stimulus and the verdict. Depends on htc_pkg, the converter and its checker.
module hotswap_telemetry_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import htc_pkg::*;

  localparam int PHASES          = 6;
  localparam int RECORDS_PER_SET = 320;
  localparam int HOLD_CYCLES     = 300;
  localparam int LIMIT_CYCLES    = 100000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_fault_byte;
  logic [7:0]           in_warn_byte;
  logic signed [15:0]   in_current_raw;
  logic signed [15:0]   in_vo_raw;
  logic signed [15:0]   in_vin_raw;
  logic signed [15:0]   in_power_raw;
  logic signed [15:0]   in_temp_raw;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_fault_code;
  logic                 out_pwr_ok;
  logic                 out_dev_off;
  logic [14:0]          out_current_10ma;
  logic signed [15:0]   out_vo_10mv;
  logic signed [15:0]   out_vi_10mv;
  logic [14:0]          out_power_100mw;
  logic signed [11:0]   out_temp_degc;
  logic signed [31:0]   out_energy_uwh;
  int                   mismatch_count;
  int                   pending_count;
  int                   checked_count;

  int                   records_sent;
  logic signed [15:0]   current_floor;
  logic signed [15:0]   power_floor;

  hotswap_telemetry_converter uut (.*);
  hotswap_telemetry_converter_checker checker_i (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CURRENT_FLOOR;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_fault_byte  = '0;
    in_warn_byte   = '0;
    in_current_raw = '0;
    in_vo_raw      = '0;
    in_vin_raw     = '0;
    in_power_raw   = '0;
    in_temp_raw    = '0;
    out_ready      = 1'b0;
    records_sent   = 0;
    current_floor  = CURRENT_FLOOR_RST;
    power_floor    = POWER_FLOOR_RST;
  end

  // Both sides run without gaps while this many records have gone out.
  function automatic bit no_gap_stretch();
    return records_sent >= 700 && records_sent < 1000;
  endfunction

  function automatic logic signed [15:0] rand_word(input logic signed [15:0] center);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(128)) - 64);
      2: return 16'(int'(center) + int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_status();
    if ($urandom_range(1)) return 8'($urandom);
    return 8'($urandom & $urandom & $urandom);
  endfunction

  task automatic send_record(input logic [7:0] fb, input logic [7:0] wb,
                             input logic signed [15:0] cur, input logic signed [15:0] vo,
                             input logic signed [15:0] vi, input logic signed [15:0] pw,
                             input logic signed [15:0] tr);
    @(negedge clk);
    while (!no_gap_stretch() && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_fault_byte  <= fb;
    in_warn_byte   <= wb;
    in_current_raw <= cur;
    in_vo_raw      <= vo;
    in_vin_raw     <= vi;
    in_power_raw   <= pw;
    in_temp_raw    <= tr;
    do @(posedge clk); while (!in_ready);
    records_sent++;
  endtask

  // Stops offering records and waits until every result is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random back-pressure, one long hold-off while the sender keeps offering.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && records_sent >= 1200) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gap_stretch() || $urandom_range(99) >= 13;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles with %0d results outstanding", cycle_count,
             pending_count);
    $display("[hotswap_telemetry_converter] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] cur_floors[PHASES];
    logic signed [15:0] pwr_floors[PHASES];
    cur_floors = '{16'sd12, -16'sd32768, 16'sd32767, 16'sd0, -16'sd200, 16'sd0};
    pwr_floors = '{16'sd5, -16'sd32768, 16'sd32767, 16'sd0, -16'sd40, 16'sd0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed records under the reset floors.
    send_record(8'h00, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_record(8'hff, 8'hff, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_record(8'h00, 8'h00, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768);
    send_record(8'h02, 8'h00, 16'sd100, 16'sd100, 16'sd100, 16'sd100, -16'sd1);
    send_record(8'h00, 8'h01, 16'sd100, 16'sd100, 16'sd100, 16'sd100, -16'sd17);
    send_record(8'h01, 8'h00, 16'sd200, -16'sd100, -16'sd100, 16'sd200, 16'sd15);
    send_record(8'h10, 8'h00, 16'sd300, 16'sd300, 16'sd300, 16'sd300, 16'sd16);
    send_record(8'h04, 8'h00, 16'sd400, 16'sd400, 16'sd400, 16'sd400, -16'sd16);
    send_record(8'h08, 8'h00, 16'sd500, 16'sd500, 16'sd500, 16'sd500, 16'sd1000);
    // Device off together with power good.
    send_record(8'h40, 8'h08, 16'sd600, 16'sd600, 16'sd600, 16'sd600, 16'sd0);
    // Only the ignored status bits are set.
    send_record(8'ha0, 8'hf6, 16'sd700, 16'sd700, 16'sd700, 16'sd700, 16'sd0);
    // A shorted switch outranks breaker, overvoltage, overtemperature and overcurrent.
    send_record(8'h1d, 8'h01, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // Raw current and power exactly at, then just below, their floors.
    send_record(8'h00, 8'h00, 16'sd12, 16'sd0, 16'sd0, 16'sd5, 16'sd0);
    send_record(8'h00, 8'h00, 16'sd11, 16'sd0, 16'sd0, 16'sd4, 16'sd0);
    // Around the saturation points of every scaled value.
    send_record(8'h00, 8'h00, 16'sd13033, 16'sd15006, 16'sd14988, 16'sd1377, 16'sd0);
    send_record(8'h00, 8'h00, 16'sd13034, 16'sd15007, 16'sd14990, 16'sd1378, 16'sd0);
    send_record(8'h00, 8'h00, 16'sd0, -16'sd15060, -16'sd15020, 16'sd0, 16'sd0);
    send_record(8'h00, 8'h00, 16'sd0, -16'sd15100, -16'sd15050, 16'sd0, 16'sd0);
    send_record(8'h00, 8'h00, 16'sd0, -16'sd24, -16'sd12, 16'sd0, 16'sd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == PHASES - 1) begin
        cur_floors[p] = 16'($urandom);
        pwr_floors[p] = 16'($urandom);
      end
      write_reg(REG_CURRENT_FLOOR, cur_floors[p]);
      write_reg(REG_POWER_FLOOR, pwr_floors[p]);
      current_floor = cur_floors[p];
      power_floor   = pwr_floors[p];
      repeat (RECORDS_PER_SET) begin
        send_record(rand_status(), rand_status(), rand_word(current_floor), rand_word(16'sd0),
                    rand_word(16'sd0), rand_word(power_floor), rand_word(16'sd0));
      end
    end

    drain();
    $display("%0d records sent under %0d floor settings, %0d results checked", records_sent,
             PHASES + 1, checked_count);
    $display("included full-scale, saturating and below-floor words, every fault priority,");
    $display("and a %0d-cycle output hold-off with the input kept busy", HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[hotswap_telemetry_converter] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[hotswap_telemetry_converter] ERROR");
    end
    $finish;
  end

endmodule

// ----- hotswap_telemetry_converter.f -----
hdl/htc_pkg.sv
hdl/htc_convert.sv
hdl/hotswap_telemetry_converter.sv
tb/hotswap_telemetry_converter_checker.sv
tb/hotswap_telemetry_converter_test.sv
